[src/scp_pkg.sv]
// ============================================================================
// scp_pkg: shared types and constants of the sphere clearance block
// Coordinate widths, derived datapath widths, register indexes and the
// packed payload structs of the point, result and internal item channels.
// ============================================================================
package scp_pkg;

    // Coordinate format: signed, 16 fraction bits.
    localparam int COORD_W   = 32;
    localparam int MAX_DIMS  = 4;
    localparam int NUM_LANES = 4;
    localparam int DIMS_W    = 3;

    // Derived datapath widths.
    localparam int RAD_W  = COORD_W - 1;       // unsigned radius
    localparam int MAG_W  = COORD_W + 1;       // magnitude of one offset
    localparam int SQ_W   = 2 * COORD_W + 1;   // one squared offset
    localparam int SUM_W  = SQ_W + 2;          // sum over four lanes
    localparam int ROOT_W = COORD_W + 2;       // distance
    localparam int RADC_W = 2 * ROOT_W;        // radicand, two bits per root bit
    localparam int REM_W  = ROOT_W + 3;        // square root partial remainder
    localparam int PROD_W = MAG_W + RAD_W;     // offset magnitude times radius
    localparam int QUO_W  = COORD_W + 1;       // quotient bits kept
    localparam int HI_W   = PROD_W - QUO_W;    // product bits above the quotient

    localparam int CFG_IDX_W = 3;

    localparam logic [DIMS_W-1:0]  DIMS_RESET   = 3'd4;
    localparam logic [RAD_W-1:0]   RADIUS_RESET = 31'd65536;
    localparam logic [DIMS_W-1:0]  DIMS_LIMIT   = DIMS_W'(MAX_DIMS);
    localparam logic [COORD_W-1:0] COORD_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN    = {1'b1, {(COORD_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSIONS = 3'd0,
        CFG_RADIUS     = 3'd1,
        CFG_CENTER_X   = 3'd2,
        CFG_CENTER_Y   = 3'd3,
        CFG_CENTER_Z   = 3'd4,
        CFG_CENTER_W   = 3'd5
    } cfg_index_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [DIMS_W-1:0]                  dims;
        logic [RAD_W-1:0]                   radius;
        logic [NUM_LANES-1:0][COORD_W-1:0]  center;
    } scp_cfg_t;

    // One input point.
    typedef struct packed {
        logic [DIMS_W-1:0]         point_dims;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] point_w;
    } scp_point_t;

    // One result.
    typedef struct packed {
        logic signed [COORD_W-1:0] clearance;
        logic                      inside_res;
        logic [DIMS_W-1:0]         used_dims;
        logic                      degenerate;
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic signed [COORD_W-1:0] proj_z;
        logic signed [COORD_W-1:0] proj_w;
    } scp_result_t;

    // Classified item passed from the front end to the arithmetic pipeline.
    typedef struct packed {
        logic [DIMS_W-1:0]                used;
        logic [NUM_LANES-1:0]             neg;
        logic [NUM_LANES-1:0][MAG_W-1:0]  mag;
    } scp_item_t;

endpackage

[src/scp_front.sv]
// ============================================================================
// scp_front: point intake and classification
// Registers each accepted point after working out the dimensions in use,
// the sign of every offset from the center and the magnitude of each used one.
// ============================================================================
module scp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  scp_pkg::scp_cfg_t cfg,
    input  logic              point_valid,
    output logic              point_stall,
    input  scp_pkg::scp_point_t point,
    output logic              item_valid,
    input  logic              item_full,
    output scp_pkg::scp_item_t item
);
    import scp_pkg::*;

    logic [COORD_W-1:0]      pt [NUM_LANES];
    logic signed [MAG_W-1:0] diff [NUM_LANES];
    logic [DIMS_W-1:0]       pd_clamp;
    logic [DIMS_W-1:0]       sd_clamp;
    logic [DIMS_W-1:0]       used;
    scp_item_t               item_next;
    scp_item_t               item_reg;
    logic                    valid_reg;
    logic                    front_adv;

    assign pt[0] = point.point_x;
    assign pt[1] = point.point_y;
    assign pt[2] = point.point_z;
    assign pt[3] = point.point_w;

    // Dimensions in use and offsets from the center.
    always_comb
    begin
        pd_clamp = (point.point_dims > DIMS_LIMIT) ? DIMS_LIMIT : point.point_dims;
        sd_clamp = (cfg.dims > DIMS_LIMIT) ? DIMS_LIMIT : cfg.dims;
        used     = (pd_clamp < sd_clamp) ? pd_clamp : sd_clamp;
        item_next.used = used;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            diff[i] = $signed({pt[i][COORD_W-1], pt[i]})
                    - $signed({cfg.center[i][COORD_W-1], cfg.center[i]});
            item_next.neg[i] = diff[i][MAG_W-1];
            if (DIMS_W'(i) < used)
            begin
                item_next.mag[i] = diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
            end
            else
            begin
                item_next.mag[i] = '0;
            end
        end
    end

    // The stage moves when it is empty or the queue takes its item.
    assign front_adv   = !valid_reg || !item_full;
    assign point_stall = !front_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            valid_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv && point_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/scp_queue.sv]
// ============================================================================
// scp_queue: short queue between front end and arithmetic pipeline
// A small register FIFO that lets intake continue while the pipeline is held.
// ============================================================================
module scp_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_full,
    input  scp_pkg::scp_item_t wr_data,
    output logic               rd_valid,
    input  logic               rd_take,
    output scp_pkg::scp_item_t rd_data
);
    import scp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    scp_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign wr_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && !wr_full;
    assign pop      = rd_valid && rd_take;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/scp_back.sv]
// ============================================================================
// scp_back: distance, clearance and projection pipeline
// Squares and scales the offsets, takes the square root one bit per stage,
// divides the scaled offsets by the distance one bit per stage, and
// saturates the results into the output register.
// ============================================================================
module scp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scp_pkg::scp_cfg_t    cfg,
    input  logic                 rd_valid,
    output logic                 rd_take,
    input  scp_pkg::scp_item_t   rd_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output scp_pkg::scp_result_t result
);
    import scp_pkg::*;

    localparam int PW = COORD_W + 3;
    localparam logic signed [ROOT_W:0] CLR_MIN =
        {{(ROOT_W + 2 - COORD_W){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [DIMS_W-1:0]                used;
        logic [NUM_LANES-1:0]             neg;
        logic [NUM_LANES-1:0][PROD_W-1:0] prod;
    } sq_side_t;

    typedef struct packed {
        logic [DIMS_W-1:0]                used;
        logic [NUM_LANES-1:0]             neg;
        logic [NUM_LANES-1:0]             ovf;
        logic                             degen;
        logic                             in_sphere;
        logic [COORD_W-1:0]               clearance;
        logic [ROOT_W-1:0]                d;
        logic [NUM_LANES-1:0][QUO_W-1:0]  prod;
    } dv_side_t;

    logic adv;

    // Multiply stage.
    logic                             a_valid_reg;
    logic [DIMS_W-1:0]                a_used_reg;
    logic [NUM_LANES-1:0]             a_neg_reg;
    logic [NUM_LANES-1:0][SQ_W-1:0]   a_sq_reg;
    logic [NUM_LANES-1:0][PROD_W-1:0] a_prod_reg;
    logic [2*MAG_W-1:0]               sq_full [NUM_LANES];
    logic [PROD_W-1:0]                prod_full [NUM_LANES];
    logic [SUM_W-1:0]                 sum_c;

    // Square root stages; entry zero is the sum stage.
    logic [ROOT_W:0]    sq_valid_reg;
    logic [REM_W-1:0]   sq_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]  sq_root_reg [ROOT_W+1];
    logic [RADC_W-1:0]  sq_rad_reg  [ROOT_W+1];
    sq_side_t           sq_side_reg [ROOT_W+1];

    // Division stages; entry zero is the clearance stage.
    logic [QUO_W:0]                     dv_valid_reg;
    logic [NUM_LANES-1:0][ROOT_W-1:0]   dv_rem_reg  [QUO_W+1];
    logic [NUM_LANES-1:0][QUO_W-1:0]    dv_q_reg    [QUO_W+1];
    dv_side_t                           dv_side_reg [QUO_W+1];

    // Clearance stage signals.
    logic [ROOT_W-1:0]                  d_c;
    logic signed [ROOT_W:0]             clr_c;
    dv_side_t                           dv_side_c;
    logic [NUM_LANES-1:0][ROOT_W-1:0]   rem0_c;
    logic [HI_W-1:0]                    hi_c [NUM_LANES];

    // Final stage signals.
    logic signed [PW-1:0]  s_c  [NUM_LANES];
    logic [COORD_W-1:0]    proj_c [NUM_LANES];
    scp_result_t           res_c;
    scp_result_t           out_reg;
    logic                  out_valid_reg;

    // The whole pipeline moves unless a finished result is held.
    assign adv     = !out_valid_reg || !result_stall;
    assign rd_take = adv;

    // Squares and radius products.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            sq_full[i]   = rd_data.mag[i] * rd_data.mag[i];
            prod_full[i] = rd_data.mag[i] * cfg.radius;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_used_reg <= rd_data.used;
            a_neg_reg  <= rd_data.neg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                a_sq_reg[i]   <= sq_full[i][SQ_W-1:0];
                a_prod_reg[i] <= prod_full[i];
            end
        end
    end

    // Sum of squares into the first square root entry.
    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            sum_c = sum_c + SUM_W'(a_sq_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]       <= '0;
            sq_root_reg[0]      <= '0;
            sq_rad_reg[0]       <= {{(RADC_W-SUM_W){1'b0}}, sum_c};
            sq_side_reg[0].used <= a_used_reg;
            sq_side_reg[0].neg  <= a_neg_reg;
            sq_side_reg[0].prod <= a_prod_reg;
        end
    end

    // One root bit per stage, two radicand bits consumed each time.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] cmpv;
        logic             ge;

        always_comb
        begin
            trial = {sq_rem_reg[k][REM_W-3:0], sq_rad_reg[k][RADC_W-1 -: 2]};
            cmpv  = {1'b0, sq_root_reg[k], 2'b01};
            ge    = (trial >= cmpv);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k+1]  <= ge ? trial - cmpv : trial;
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], ge};
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][RADC_W-3:0], 2'b00};
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // Clearance, flags and quotient overflow checks.
    always_comb
    begin
        d_c   = sq_root_reg[ROOT_W];
        clr_c = $signed({{(ROOT_W + 1 - RAD_W){1'b0}}, cfg.radius}) - $signed({1'b0, d_c});
        dv_side_c.used   = sq_side_reg[ROOT_W].used;
        dv_side_c.neg    = sq_side_reg[ROOT_W].neg;
        dv_side_c.degen  = (d_c == '0);
        dv_side_c.in_sphere = !clr_c[ROOT_W];
        dv_side_c.clearance = (clr_c < CLR_MIN) ? COORD_MIN : clr_c[COORD_W-1:0];
        dv_side_c.d      = d_c;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            hi_c[i]   = sq_side_reg[ROOT_W].prod[i][PROD_W-1 -: HI_W];
            rem0_c[i] = ROOT_W'(hi_c[i]);
            // A quotient at or above 2^QUO_W saturates whatever the center.
            dv_side_c.ovf[i]  = (rem0_c[i] >= d_c);
            dv_side_c.prod[i] = sq_side_reg[ROOT_W].prod[i][QUO_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0]  <= rem0_c;
            dv_q_reg[0]    <= '0;
            dv_side_reg[0] <= dv_side_c;
        end
    end

    // One quotient bit per stage for every lane.
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic [NUM_LANES-1:0][ROOT_W:0]   rem2;
        logic [NUM_LANES-1:0][ROOT_W:0]   sub;
        logic [NUM_LANES-1:0][ROOT_W-1:0] rem_n;
        logic [NUM_LANES-1:0]             ge;
        logic [ROOT_W:0]                  dext;

        always_comb
        begin
            dext = {1'b0, dv_side_reg[j].d};
            for (int i = 0; i < NUM_LANES; i++)
            begin
                rem2[i]  = {dv_rem_reg[j][i], dv_side_reg[j].prod[i][QUO_W-1-j]};
                sub[i]   = rem2[i] - dext;
                ge[i]    = (rem2[i] >= dext);
                rem_n[i] = ge[i] ? sub[i][ROOT_W-1:0] : rem2[i][ROOT_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    dv_rem_reg[j+1][i] <= rem_n[i];
                    dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QUO_W-2:0], ge[i]};
                end
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // Projection onto the surface with saturation.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (dv_side_reg[QUO_W].neg[i])
            begin
                s_c[i] = $signed({{3{cfg.center[i][COORD_W-1]}}, cfg.center[i]})
                       - $signed({2'b00, dv_q_reg[QUO_W][i]});
            end
            else
            begin
                s_c[i] = $signed({{3{cfg.center[i][COORD_W-1]}}, cfg.center[i]})
                       + $signed({2'b00, dv_q_reg[QUO_W][i]});
            end

            if (DIMS_W'(i) >= dv_side_reg[QUO_W].used)
            begin
                proj_c[i] = '0;
            end
            else if (dv_side_reg[QUO_W].degen)
            begin
                proj_c[i] = cfg.center[i];
            end
            else if (dv_side_reg[QUO_W].ovf[i])
            begin
                proj_c[i] = dv_side_reg[QUO_W].neg[i] ? COORD_MIN : COORD_MAX;
            end
            else if (s_c[i][PW-1:COORD_W-1] != {(PW - COORD_W + 1){s_c[i][PW-1]}})
            begin
                proj_c[i] = s_c[i][PW-1] ? COORD_MIN : COORD_MAX;
            end
            else
            begin
                proj_c[i] = s_c[i][COORD_W-1:0];
            end
        end

        res_c.clearance  = dv_side_reg[QUO_W].clearance;
        res_c.inside_res = dv_side_reg[QUO_W].in_sphere;
        res_c.used_dims  = dv_side_reg[QUO_W].used;
        res_c.degenerate = dv_side_reg[QUO_W].degen;
        res_c.proj_x     = proj_c[0];
        res_c.proj_y     = proj_c[1];
        res_c.proj_z     = proj_c[2];
        res_c.proj_w     = proj_c[3];
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            sq_valid_reg  <= '0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= rd_valid;
            sq_valid_reg  <= {sq_valid_reg[ROOT_W-1:0], a_valid_reg};
            dv_valid_reg  <= {dv_valid_reg[QUO_W-1:0], sq_valid_reg[ROOT_W]};
            out_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res_c;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[src/sphere_clearance_and_projection_top.sv]
// ============================================================================
// sphere_clearance_and_projection_top: point to sphere clearance and projection
// Configuration registers, point intake, queue and arithmetic pipeline.
// ============================================================================
//
//  channel   handshake                   payload
//  -------   -------------------------   -----------------------------
//  point     point_valid / point_stall   point  (scp_point_t)
//  result    result_valid / result_stall result (scp_result_t)
//  config    cfg_write_en                cfg_index, cfg_data
//
//  One point per cycle sustained while no result is stalled. Each result
//  passes through the square root, which yields one distance bit per stage
//  (34 stages), the divider, one quotient bit per stage (33 stages), and
//  the intake, queue, multiply, sum, clearance and output registers. Reset
//  clears all valid state and loads the register defaults. A stalled result
//  freezes the pipeline; intake keeps accepting until the front register
//  and the two-entry queue are full.
//
module sphere_clearance_and_projection_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [scp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [scp_pkg::COORD_W-1:0]            cfg_data,
    input  logic                                   point_valid,
    output logic                                   point_stall,
    input  scp_pkg::scp_point_t                    point,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output scp_pkg::scp_result_t                   result
);
    import scp_pkg::*;

    scp_cfg_t  cfg_reg;
    logic      item_valid;
    logic      item_full;
    scp_item_t item;
    logic      rd_valid;
    logic      rd_take;
    scp_item_t rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dims   <= DIMS_RESET;
            cfg_reg.radius <= RADIUS_RESET;
            cfg_reg.center <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DIMENSIONS: cfg_reg.dims      <= cfg_data[DIMS_W-1:0];
                CFG_RADIUS:     cfg_reg.radius    <= cfg_data[RAD_W-1:0];
                CFG_CENTER_X:   cfg_reg.center[0] <= cfg_data;
                CFG_CENTER_Y:   cfg_reg.center[1] <= cfg_data;
                CFG_CENTER_Z:   cfg_reg.center[2] <= cfg_data;
                CFG_CENTER_W:   cfg_reg.center[3] <= cfg_data;
                default:        ;
            endcase
        end
    end

    scp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .item_valid  (item_valid),
        .item_full   (item_full),
        .item        (item)
    );

    scp_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (item_valid),
        .wr_full  (item_full),
        .wr_data  (item),
        .rd_valid (rd_valid),
        .rd_take  (rd_take),
        .rd_data  (rd_data)
    );

    scp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .rd_valid     (rd_valid),
        .rd_take      (rd_take),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[src/scp_checker.sv]
// ============================================================================
// scp_checker: port level checks of the sphere clearance block
// Watches the top level ports and is attached to it by a bind statement.
// ============================================================================
module scp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_stall,
    input scp_pkg::scp_result_t          result
);
    import scp_pkg::*;

    // A held result stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("held result changed or dropped");

    // The inside flag agrees with the sign of the clearance.
    a_inside_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.inside_res == !result.clearance[COORD_W-1]))
        else $error("inside flag disagrees with clearance");

    // No dimensions in use gives a degenerate result with zero projection.
    a_zero_dims: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.used_dims == '0) |->
            result.degenerate && (result.proj_x == '0) && (result.proj_y == '0)
            && (result.proj_z == '0) && (result.proj_w == '0))
        else $error("zero dimension result is wrong");

    // Dimensions in use never exceed the lane count.
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.used_dims <= DIMS_LIMIT))
        else $error("used dimensions out of range");

endmodule

bind sphere_clearance_and_projection_top scp_checker u_scp_checker (.*);
